// ----- design/brs_pkg.sv -----
package brs_pkg;

   localparam int MAX_VERTICES_DEF = 1024;
   localparam int COORD_W          = 32;
   localparam int VTX_W            = 3 * COORD_W;
   localparam int SQ_W             = 64;
   localparam int DEN_W            = 34;

   typedef enum logic {
      ITU_SQRT,
      ITU_DIV
   } itu_op_type;

   typedef struct packed {
      logic       start;
      itu_op_type op;
   } itu_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } itu_stat_type;

endpackage

// ----- design/brs_ram.sv -----
module brs_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/brs_itu.sv -----
module brs_itu (
   input  logic                            clock,
   input  logic                            reset,
   input  brs_pkg::itu_req_type            req,
   input  logic [brs_pkg::SQ_W-1:0]        num,
   input  logic [brs_pkg::DEN_W-1:0]       den,
   output brs_pkg::itu_stat_type           stat,
   output logic [brs_pkg::SQ_W-1:0]        result
);

   // shared restoring unit: one result bit per step; sqrt takes two radicand bits per step, divide one
   logic                       busy_ff;
   logic                       done_ff;
   brs_pkg::itu_op_type        op_ff;
   logic [6:0]                 cnt_ff;
   logic [35:0]                rem_ff;
   logic [brs_pkg::SQ_W-1:0]   work_ff;
   logic [brs_pkg::SQ_W-1:0]   res_ff;
   logic [brs_pkg::DEN_W-1:0]  den_ff;

   logic [35:0]                rem_t;
   logic [35:0]                trial;
   logic                       ge;
   logic [35:0]                rem_in;
   logic [brs_pkg::SQ_W-1:0]   work_in;

   always_comb begin
      if (op_ff == brs_pkg::ITU_SQRT) begin
         rem_t   = {rem_ff[33:0], work_ff[63:62]};
         trial   = {2'b00, res_ff[31:0], 2'b01};
         work_in = {work_ff[61:0], 2'b00};
      end else begin
         rem_t   = {rem_ff[34:0], work_ff[63]};
         trial   = {2'b00, den_ff};
         work_in = {work_ff[62:0], 1'b0};
      end
      ge     = (rem_t >= trial);
      rem_in = ge ? (rem_t - trial) : rem_t;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            op_ff   <= req.op;
            cnt_ff  <= (req.op == brs_pkg::ITU_SQRT) ? 7'd32 : 7'd64;
            rem_ff  <= '0;
            res_ff  <= '0;
            work_ff <= num;
            den_ff  <= den;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            work_ff <= work_in;
            res_ff  <= {res_ff[62:0], ge};
            cnt_ff  <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = res_ff;

endmodule

// ----- design/bounding_sphere_ritter.sv -----
// bounding sphere (ritter) over a set of signed q16.16 vertices
//
// input channel req_*: one vertex per transfer; req_last marks the final
// vertex of a set. vertices are written to an on-chip store while the six
// axis extremes are tracked in registers, one vertex per cycle. vertices
// past MAX_VERTICES are dropped, but their last flag still ends the set.
// after the last vertex the block stops taking input and computes: axis
// pick, first radius, then one pass over the store. a vertex inside the
// sphere is only fetched and tested; one outside it also needs a 32-step
// square root and three 64-step divides in the shared iterative unit.
// result channel rsp_*: one transfer per set with centre and radius. the
// result is held until rsp_ready; while it waits no new vertex is taken,
// and after its transfer the block accepts the next set at once.
// reset (synchronous) empties the set and drops any pending result; the
// vertex store has no clearing pass since only entries of the current set
// are ever read.
module bounding_sphere_ritter #(
   parameter int MAX_VERTICES = brs_pkg::MAX_VERTICES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [31:0]  req_vertex_x,
   input  logic signed [31:0]  req_vertex_y,
   input  logic signed [31:0]  req_vertex_z,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_center_x,
   output logic signed [31:0]  rsp_center_y,
   output logic signed [31:0]  rsp_center_z,
   output logic [31:0]         rsp_sphere_radius
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int CRD = brs_pkg::COORD_W;

   typedef enum logic [4:0] {
      S_LOAD, S_AXIS, S_SQ, S_AXIS_DONE, S_PICK, S_CENTER, S_RSQ, S_RSQRT,
      S_FETCH, S_FETCH_W, S_TEST, S_DSQRT, S_MUL, S_DIVS, S_DIVW, S_RAD,
      S_RSQ2, S_RSQ3, S_OUT
   } state_type;

   function automatic logic [31:0] abs_diff(logic signed [31:0] a,
                                            logic signed [31:0] b);
      logic signed [32:0] d;
      d = 33'(a) - 33'(b);
      abs_diff = d[32] ? 32'(-d) : d[31:0];
   endfunction

   state_type                  state_ff;
   state_type                  ret_ff;
   logic [CW-1:0]              cnt_ff;
   logic [CW-1:0]              idx_ff;
   logic [brs_pkg::VTX_W-1:0]  ext_ff [6];
   logic [1:0]                 ax_ff;
   logic [63:0]                axd_ff [3];
   logic [1:0]                 sq_k_ff;
   logic signed [31:0]         opa_ff [3];
   logic signed [31:0]         opb_ff [3];
   logic [63:0]                prod_ff;
   logic [63:0]                acc_ff;
   logic [63:0]                rsq_ff;
   logic [31:0]                r_ff;
   logic [31:0]                d_ff;
   logic [31:0]                grow_ff;
   logic signed [31:0]         ctr_ff [3];
   logic                       rsp_valid_ff;

   logic                       req_xfer;
   logic [brs_pkg::VTX_W-1:0]  vtx_in;
   logic [brs_pkg::VTX_W-1:0]  rd_data;
   logic [1:0]                 tk;
   logic [31:0]                mul_a;
   logic [31:0]                mul_b;
   logic [63:0]                prod_in;
   logic [64:0]                acc_sum;
   logic [63:0]                acc_in;
   logic [1:0]                 pick;
   logic                       v_neg;
   logic [31:0]                q;
   logic signed [33:0]         ctr_sum;
   logic signed [31:0]         ctr_in;
   brs_pkg::itu_req_type       itu_req;
   brs_pkg::itu_stat_type      itu_stat;
   logic [63:0]                itu_num;
   logic [63:0]                itu_res;

   assign req_xfer = req_valid && req_ready;
   assign vtx_in   = {req_vertex_z, req_vertex_y, req_vertex_x};

   brs_ram #(
      .WIDTH(brs_pkg::VTX_W),
      .DEPTH(MAX_VERTICES)
   ) u_store (
      .clock  (clock),
      .wr_en  (req_xfer && (cnt_ff < CW'(MAX_VERTICES))),
      .wr_addr(cnt_ff[AW-1:0]),
      .wr_data(vtx_in),
      .rd_addr(idx_ff[AW-1:0]),
      .rd_data(rd_data)
   );

   // shared multiplier: squared terms, scaled offset, new radius squared
   assign tk = (sq_k_ff == 2'd3) ? 2'd0 : sq_k_ff;
   always_comb begin
      case (state_ff)
         S_SQ: begin
            mul_a = abs_diff(opa_ff[tk], opb_ff[tk]);
            mul_b = mul_a;
         end
         S_MUL: begin
            mul_a = abs_diff(opb_ff[ax_ff], ctr_ff[ax_ff]);
            mul_b = grow_ff;
         end
         default: begin
            mul_a = r_ff;
            mul_b = r_ff;
         end
      endcase
   end
   assign prod_in = mul_a * mul_b;

   // saturating accumulate of squared distance
   assign acc_sum = {1'b0, acc_ff} + {1'b0, prod_ff};
   assign acc_in  = acc_sum[64] ? '1 : acc_sum[63:0];

   // later axis wins on equal spread
   always_comb begin
      if (axd_ff[2] >= axd_ff[0] && axd_ff[2] >= axd_ff[1]) begin
         pick = 2'd2;
      end else if (axd_ff[1] >= axd_ff[0] && axd_ff[1] >= axd_ff[2]) begin
         pick = 2'd1;
      end else begin
         pick = 2'd0;
      end
   end

   // centre shift toward the outside vertex, saturated to 32 bits
   assign v_neg   = (opb_ff[ax_ff] < ctr_ff[ax_ff]);
   assign q       = itu_res[31:0];
   assign ctr_sum = v_neg ? (34'(ctr_ff[ax_ff]) - $signed({2'b00, q}))
                          : (34'(ctr_ff[ax_ff]) + $signed({2'b00, q}));
   always_comb begin
      if (ctr_sum > 34'sd2147483647) begin
         ctr_in = 32'sh7fffffff;
      end else if (ctr_sum < -34'sd2147483648) begin
         ctr_in = 32'sh80000000;
      end else begin
         ctr_in = ctr_sum[31:0];
      end
   end

   always_comb begin
      itu_req.start = (state_ff == S_RSQ) || (state_ff == S_DIVS)
                   || ((state_ff == S_TEST) && (acc_ff > rsq_ff));
      itu_req.op    = (state_ff == S_DIVS) ? brs_pkg::ITU_DIV : brs_pkg::ITU_SQRT;
      itu_num       = (state_ff == S_DIVS) ? prod_ff : acc_ff;
   end

   brs_itu u_itu (
      .clock (clock),
      .reset (reset),
      .req   (itu_req),
      .num   (itu_num),
      .den   ({1'b0, d_ff, 1'b0}),
      .stat  (itu_stat),
      .result(itu_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         ret_ff       <= S_LOAD;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_LOAD: begin
               if (req_xfer) begin
                  if (cnt_ff < CW'(MAX_VERTICES)) begin
                     cnt_ff <= cnt_ff + CW'(1);
                     for (int k = 0; k < 3; k++) begin
                        if (cnt_ff == '0 || $signed(vtx_in[CRD*k +: CRD])
                              < $signed(ext_ff[2*k][CRD*k +: CRD])) begin
                           ext_ff[2*k] <= vtx_in;
                        end
                        if (cnt_ff == '0 || $signed(vtx_in[CRD*k +: CRD])
                              > $signed(ext_ff[2*k+1][CRD*k +: CRD])) begin
                           ext_ff[2*k+1] <= vtx_in;
                        end
                     end
                  end
                  if (req_last) begin
                     ax_ff    <= 2'd0;
                     state_ff <= S_AXIS;
                  end
               end
            end
            S_AXIS: begin
               for (int k = 0; k < 3; k++) begin
                  opa_ff[k] <= ext_ff[{ax_ff, 1'b0}][CRD*k +: CRD];
                  opb_ff[k] <= ext_ff[{ax_ff, 1'b1}][CRD*k +: CRD];
               end
               sq_k_ff  <= 2'd0;
               ret_ff   <= S_AXIS_DONE;
               state_ff <= S_SQ;
            end
            S_SQ: begin
               prod_ff <= prod_in;
               acc_ff  <= (sq_k_ff == 2'd0) ? '0 : acc_in;
               sq_k_ff <= sq_k_ff + 2'd1;
               if (sq_k_ff == 2'd3) begin
                  state_ff <= ret_ff;
               end
            end
            S_AXIS_DONE: begin
               axd_ff[ax_ff] <= acc_ff;
               ax_ff         <= ax_ff + 2'd1;
               state_ff      <= (ax_ff == 2'd2) ? S_PICK : S_AXIS;
            end
            S_PICK: begin
               for (int k = 0; k < 3; k++) begin
                  ctr_ff[k] <= 32'((34'($signed(ext_ff[{pick, 1'b0}][CRD*k +: CRD]))
                             + 34'($signed(ext_ff[{pick, 1'b1}][CRD*k +: CRD]))
                             + 34'((34'($signed(ext_ff[{pick, 1'b0}][CRD*k +: CRD]))
                             + 34'($signed(ext_ff[{pick, 1'b1}][CRD*k +: CRD]))) < 0))
                             >>> 1);
                  opb_ff[k] <= ext_ff[{pick, 1'b0}][CRD*k +: CRD];
               end
               state_ff <= S_CENTER;
            end
            S_CENTER: begin
               opa_ff   <= ctr_ff;
               sq_k_ff  <= 2'd0;
               ret_ff   <= S_RSQ;
               state_ff <= S_SQ;
            end
            S_RSQ: begin
               rsq_ff   <= acc_ff;
               state_ff <= S_RSQRT;
            end
            S_RSQRT: begin
               if (itu_stat.done) begin
                  r_ff     <= itu_res[31:0];
                  idx_ff   <= '0;
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: begin
               if (idx_ff == cnt_ff) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_OUT;
               end else begin
                  state_ff <= S_FETCH_W;
               end
            end
            S_FETCH_W: begin
               for (int k = 0; k < 3; k++) begin
                  opb_ff[k] <= rd_data[CRD*k +: CRD];
               end
               opa_ff   <= ctr_ff;
               sq_k_ff  <= 2'd0;
               ret_ff   <= S_TEST;
               state_ff <= S_SQ;
            end
            S_TEST: begin
               if (acc_ff > rsq_ff) begin
                  state_ff <= S_DSQRT;
               end else begin
                  idx_ff   <= idx_ff + CW'(1);
                  state_ff <= S_FETCH;
               end
            end
            S_DSQRT: begin
               if (itu_stat.done) begin
                  d_ff     <= itu_res[31:0];
                  grow_ff  <= itu_res[31:0] - r_ff;
                  ax_ff    <= 2'd0;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= S_DIVS;
            end
            S_DIVS: begin
               state_ff <= S_DIVW;
            end
            S_DIVW: begin
               if (itu_stat.done) begin
                  ctr_ff[ax_ff] <= ctr_in;
                  ax_ff         <= ax_ff + 2'd1;
                  state_ff      <= (ax_ff == 2'd2) ? S_RAD : S_MUL;
               end
            end
            S_RAD: begin
               r_ff     <= 32'(({1'b0, r_ff} + {1'b0, d_ff}) >> 1);
               state_ff <= S_RSQ2;
            end
            S_RSQ2: begin
               prod_ff  <= prod_in;
               state_ff <= S_RSQ3;
            end
            S_RSQ3: begin
               rsq_ff   <= prod_ff;
               idx_ff   <= idx_ff + CW'(1);
               state_ff <= S_FETCH;
            end
            S_OUT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  cnt_ff       <= '0;
                  state_ff     <= S_LOAD;
               end
            end
            default: begin
               state_ff <= S_LOAD;
            end
         endcase
      end
   end

   assign req_ready         = (state_ff == S_LOAD);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_center_x      = ctr_ff[0];
   assign rsp_center_y      = ctr_ff[1];
   assign rsp_center_z      = ctr_ff[2];
   assign rsp_sphere_radius = r_ff;

   // input and result sides never open together
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input and result both open");

   // set size never passes the store depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_VERTICES))
      else $error("vertex count overflow");

   // result transfer empties the set
   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> (cnt_ff == '0 && req_ready))
      else $error("set not cleared after result");

   // iterative unit is started only when free
   a_itu_free: assert property (@(posedge clock) disable iff (reset)
      itu_req.start |-> !itu_stat.busy)
      else $error("iterative unit restarted while busy");

   // pass index stays within the set
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FETCH_W) |-> (idx_ff < cnt_ff))
      else $error("read beyond set");

endmodule

// ----- tb/sphere_checker.sv -----
`timescale 1ns / 100ps

module sphere_checker #(
   parameter int NUM_SLOTS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [31:0] req_vertex_x,
   input  logic signed [31:0] req_vertex_y,
   input  logic signed [31:0] req_vertex_z,
   input  logic               req_last,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_center_x,
   input  logic signed [31:0] rsp_center_y,
   input  logic signed [31:0] rsp_center_z,
   input  logic [31:0]        rsp_sphere_radius,
   output int                 fail_count,
   output int                 spheres_due
);

   typedef logic signed [31:0] coord_type;
   typedef coord_type point_type [3];

   typedef struct {
      coord_type   cx, cy, cz;
      logic [31:0] radius;
   } sphere_type;

   point_type   vertices [NUM_SLOTS];
   int          extreme [6];
   int          loaded;
   point_type   center;
   logic [31:0] radius;
   logic [63:0] radius_sq;
   sphere_type  due_spheres [$];

   function automatic logic [63:0] dist_sq(point_type a, point_type b);
      logic [63:0] sum;
      logic [63:0] sq;
      longint      d;
      sum = 0;
      for (int k = 0; k < 3; k++) begin
         d = longint'(a[k]) - longint'(b[k]);
         if (d < 0) d = -d;
         sq = 64'(d) * 64'(d);
         if (sum > ~64'd0 - sq) return ~64'd0;
         sum = sum + sq;
      end
      return sum;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] r;
      logic [63:0] bit_w;
      r = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > x) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (x >= r + bit_w) begin
            x = x - (r + bit_w);
            r = (r >> 1) + bit_w;
         end else begin
            r = r >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return r;
   endfunction

   function automatic coord_type clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return coord_type'(v);
   endfunction

   // axis pick, midpoint, then one growth pass over the stored set
   task automatic fit_sphere();
      logic [63:0] span [3];
      logic [63:0] d2, d, grow, den, m;
      longint      v, step;
      int          p1, p2;
      point_type   c0;
      for (int k = 0; k < 3; k++)
         span[k] = dist_sq(vertices[extreme[2*k]], vertices[extreme[2*k+1]]);
      p1 = 0;
      p2 = 0;
      if (span[0] >= span[1] && span[0] >= span[2]) begin
         p1 = extreme[0]; p2 = extreme[1];
      end
      if (span[1] >= span[0] && span[1] >= span[2]) begin
         p1 = extreme[2]; p2 = extreme[3];
      end
      if (span[2] >= span[0] && span[2] >= span[1]) begin
         p1 = extreme[4]; p2 = extreme[5];
      end
      for (int k = 0; k < 3; k++)
         center[k] = coord_type'((longint'(vertices[p1][k]) + longint'(vertices[p2][k])) / 2);
      radius_sq = dist_sq(center, vertices[p1]);
      radius = 32'(int_sqrt(radius_sq));
      for (int i = 0; i < loaded; i++) begin
         d2 = dist_sq(center, vertices[i]);
         if (d2 > radius_sq) begin
            d = int_sqrt(d2);
            grow = d - 64'(radius);
            den = 2 * d;
            c0 = center;
            for (int k = 0; k < 3; k++) begin
               v = longint'(vertices[i][k]) - longint'(c0[k]);
               m = (v < 0) ? 64'(-v) : 64'(v);
               step = longint'((m * grow) / den);
               if (v < 0) step = -step;
               center[k] = clamp32(longint'(c0[k]) + step);
            end
            radius = 32'((64'(radius) + d) / 2);
            radius_sq = 64'(radius) * 64'(radius);
         end
      end
   endtask

   task automatic report(string field, logic [31:0] want, logic [31:0] got);
      $display("mismatch %s: expected %h, got %h at %0t", field, want, got, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      sphere_type want;
      sphere_type fresh;
      if (reset) begin
         fail_count = 0;
         loaded = 0;
         for (int k = 0; k < 6; k++) extreme[k] = 0;
         center = '{0, 0, 0};
         radius = 0;
         radius_sq = 0;
         due_spheres.delete();
      end else begin
         // vertex transfer: store and track extremes, first index wins ties
         if (req_valid && req_ready) begin
            if (loaded < NUM_SLOTS) begin
               vertices[loaded] = '{req_vertex_x, req_vertex_y, req_vertex_z};
               if (loaded == 0) begin
                  for (int k = 0; k < 6; k++) extreme[k] = 0;
               end else begin
                  for (int k = 0; k < 3; k++) begin
                     if (vertices[loaded][k] < vertices[extreme[2*k]][k])
                        extreme[2*k] = loaded;
                     if (vertices[loaded][k] > vertices[extreme[2*k+1]][k])
                        extreme[2*k+1] = loaded;
                  end
               end
               loaded = loaded + 1;
            end
            if (req_last) begin
               fit_sphere();
               fresh.cx = center[0];
               fresh.cy = center[1];
               fresh.cz = center[2];
               fresh.radius = radius;
               due_spheres = {due_spheres, fresh};
               loaded = 0;
               for (int k = 0; k < 6; k++) extreme[k] = 0;
            end
         end
         // result transfer
         if (rsp_valid && rsp_ready) begin
            if (due_spheres.size() == 0) begin
               $display("unexpected result at %0t", $realtime);
               fail_count++;
            end else begin
               want = due_spheres.pop_front();
               if (rsp_center_x !== want.cx) report("center_x", want.cx, rsp_center_x);
               if (rsp_center_y !== want.cy) report("center_y", want.cy, rsp_center_y);
               if (rsp_center_z !== want.cz) report("center_z", want.cz, rsp_center_z);
               if (rsp_sphere_radius !== want.radius)
                  report("sphere_radius", want.radius, rsp_sphere_radius);
            end
         end
      end
      spheres_due = due_spheres.size();
   end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

   // small store so the store-full case is cheap to reach
   localparam int NUM_SLOTS  = 64;
   localparam int IDLE_LIMIT = 200000;
   localparam int TAIL_WAIT  = 400;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_vertex_x;
   logic signed [31:0] req_vertex_y;
   logic signed [31:0] req_vertex_z;
   logic               req_last;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_center_x;
   logic signed [31:0] rsp_center_y;
   logic signed [31:0] rsp_center_z;
   logic [31:0]        rsp_sphere_radius;
   int                 fail_count;
   int                 spheres_due;
   int                 idle_cycles;
   int                 sent;

   bounding_sphere_ritter #(.MAX_VERTICES(NUM_SLOTS)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_vertex_x(req_vertex_x), .req_vertex_y(req_vertex_y),
      .req_vertex_z(req_vertex_z), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_center_x(rsp_center_x), .rsp_center_y(rsp_center_y),
      .rsp_center_z(rsp_center_z), .rsp_sphere_radius(rsp_sphere_radius)
   );

   sphere_checker #(.NUM_SLOTS(NUM_SLOTS)) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_vertex_x(req_vertex_x), .req_vertex_y(req_vertex_y),
      .req_vertex_z(req_vertex_z), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_center_x(rsp_center_x), .rsp_center_y(rsp_center_y),
      .rsp_center_z(rsp_center_z), .rsp_sphere_radius(rsp_sphere_radius),
      .fail_count(fail_count), .spheres_due(spheres_due)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // coordinate mix: full range, small values near zero, and the rails
   function automatic logic signed [31:0] pick_coord(int style);
      int roll;
      roll = $urandom_range(99);
      if (style == 0 || roll < 10) return $urandom;
      if (roll < 15) return (roll & 1) ? 32'sh7fffffff : 32'sh80000000;
      if (style == 1) return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
   endfunction

   // one vertex transfer; the payload changes only at the falling edge
   task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z, logic last, bit no_gap);
      int gap;
      gap = no_gap ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1;
      req_vertex_x <= x;
      req_vertex_y <= y;
      req_vertex_z <= z;
      req_last     <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   // a whole set of random vertices in one coordinate style
   task automatic send_set(int count, int style, bit no_gap);
      for (int i = 0; i < count; i++)
         send_vertex(pick_coord(style), pick_coord(style), pick_coord(style),
                     i == count - 1, no_gap);
   endtask

   // result side: random stalls, with stretches of steady ready
   initial begin
      int roll;
      rsp_ready = 0;
      @(negedge clock);
      forever begin
         roll = $urandom_range(99);
         if (roll < 30) begin
            rsp_ready <= 1;
            repeat ($urandom_range(20, 200)) @(negedge clock);
         end else if (roll < 90) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
            rsp_ready <= 1;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end else begin
            rsp_ready <= 0;
            repeat ($urandom_range(20, 300)) @(negedge clock);
         end
      end
   end

   // watchdog: cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   initial begin
      int len, style;
      reset        = 1;
      req_valid    = 0;
      req_vertex_x = 0;
      req_vertex_y = 0;
      req_vertex_z = 0;
      req_last     = 0;
      sent         = 0;
      repeat (11) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // single vertex sets at the rails and at zero: centre is the vertex, radius zero
      send_vertex(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1, 0);
      send_vertex(32'sh80000000, 32'sh7fffffff, 32'sh0, 1, 0);
      send_vertex(32'sh0, 32'sh0, 32'sh0, 1, 1);
      // opposite corners: squared distances saturate
      send_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 1);
      send_vertex(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1, 1);
      // identical vertices: ties keep the first index on every axis
      repeat (2) send_vertex(32'sh0001_0000, -32'sh0001_0000, 32'sh5, 0, 0);
      send_vertex(32'sh0001_0000, -32'sh0001_0000, 32'sh5, 1, 0);
      // equal axis spans: the later axis wins
      send_vertex(-32'sh0002_0000, 32'sh0, 32'sh0, 0, 1);
      send_vertex(32'sh0002_0000, 32'sh0, 32'sh0, 0, 1);
      send_vertex(32'sh0, 32'sh0, -32'sh0002_0000, 0, 1);
      send_vertex(32'sh0, 32'sh0, 32'sh0002_0000, 0, 1);
      send_vertex(32'sh0003_0000, 32'sh0003_0000, 32'sh0003_0000, 1, 1);
      // odd sums round toward zero; outlier forces growth
      send_vertex(-32'sh3, 32'sh3, -32'sh1, 0, 0);
      send_vertex(32'sh0, 32'sh0, 32'sh0, 0, 0);
      send_vertex(32'sh7fff0000, 32'sh80010000, 32'sh12345678, 1, 0);

      // store full: vertices past the limit are dropped, last still ends the set
      send_set(NUM_SLOTS + 5, 1, 1);

      // hold off until every result has come back
      req_valid <= 0;
      do @(negedge clock); while (spheres_due != 0);

      while (sent < 600) begin
         len = ($urandom_range(99) < 85) ? $urandom_range(1, 12)
                                         : $urandom_range(13, NUM_SLOTS + 8);
         style = $urandom_range(2);
         send_set(len, style, $urandom_range(99) < 15);
         if ($urandom_range(99) < 5) begin
            req_valid <= 0;
            do @(negedge clock); while (spheres_due != 0);
         end
      end
      req_valid <= 0;

      while (spheres_due != 0) @(negedge clock);
      repeat (TAIL_WAIT) @(negedge clock);
      if (fail_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

// ----- sim.f -----
design/brs_pkg.sv
design/brs_ram.sv
design/brs_itu.sv
design/bounding_sphere_ritter.sv
tb/sphere_checker.sv
tb/testbench.sv
